// File: hw/rtl/gal_pkg.sv
// shared types, constants and state codes of the glyph atlas slot cache
`timescale 1ns / 1ps
`default_nettype none
package gal_pkg;

    localparam int CODE_W = 21;
    localparam int POS_W  = 10;
    localparam int SIZE_W = 11;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd8;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 11'd1024;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd64;
    localparam logic [POS_W-1:0]  POS_MAX    = 10'd1023;

    localparam int ATLAS_WIDTH_DEF  = 1024;
    localparam int ATLAS_HEIGHT_DEF = 1024;
    localparam int MAX_CELLS_DEF    = 256;

    // register index is paddr bit 2
    localparam logic REG_CELL_WIDTH  = 1'b0;
    localparam logic REG_CELL_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DCOLS,
        S_DROWS,
        S_SCAN,
        S_DECIDE,
        S_UPD,
        S_DCELL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [CODE_W-1:0] glyph_code;
        logic              mode;
    } in_item_t;

    typedef struct packed {
        logic              was_resident;
        logic [POS_W-1:0]  cell_left;
        logic [POS_W-1:0]  cell_top;
        logic              evicted;
        logic [CODE_W-1:0] evicted_code;
    } out_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/glyph_atlas_lru_slot_cache_top.sv
// top level of the glyph atlas lru slot cache
`timescale 1ns / 1ps
`default_nettype none
// Fully associative lru cache that maps glyph code points to cells of a
// texture atlas cut into a row-major grid of cell_width x cell_height cells.
// Each entry of one ram (depth MAX_CELLS) holds a glyph code and its recency
// rank (0 = most recent); the entry number is the atlas cell. An item is
// handled one at a time: a serial divider finds the column and row counts,
// one scan over the cells in use finds the hit and the lru entry, one
// read-modify-write pass renumbers the ranks, and the divider then splits
// the cell number into column and row. The divider is D = clog2(max(ATLAS_WIDTH,
// ATLAS_HEIGHT, MAX_CELLS) + 1) bits wide (11 at the defaults); the time an
// item takes is set by the divider and by the single ram port pair walking
// the n cells in use. The result waits in an output register, so the next
// item is taken while it is still pending.
// Reset needs no clearing pass: only entries below the in-use count are read.
// Registers: cell_width at byte address 0, cell_height at 4, 11 bits each.
module glyph_atlas_lru_slot_cache_top
    import gal_pkg::*;
#(
    parameter int ATLAS_WIDTH  = ATLAS_WIDTH_DEF,
    parameter int ATLAS_HEIGHT = ATLAS_HEIGHT_DEF,
    parameter int MAX_CELLS    = MAX_CELLS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    // item output
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int SW    = $clog2(MAX_CELLS);
    localparam int CW    = $clog2(MAX_CELLS + 1);
    localparam int EW    = CODE_W + SW;
    localparam int DMAX1 = (ATLAS_WIDTH > ATLAS_HEIGHT) ? ATLAS_WIDTH : ATLAS_HEIGHT;
    localparam int DMAX  = (DMAX1 > MAX_CELLS) ? DMAX1 : MAX_CELLS;
    localparam int DW    = $clog2(DMAX + 1);
    localparam int PW    = 2 * DW;
    localparam int MW    = DW + SIZE_W;

    // state and configuration
    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] cw_reg, ch_reg;
    logic [SIZE_W-1:0] cwc, chc;

    // item under work
    logic [CODE_W-1:0] code_reg;
    logic              peek_reg;
    logic [DW-1:0]     cols_reg, rows_reg;
    logic [CW-1:0]     n_reg;

    // walk counters
    logic [CW-1:0]     iss_reg;
    logic              pv_reg;
    logic [SW-1:0]     ps_reg;
    logic              walk_end;

    // scan results
    logic              hit_reg;
    logic [SW-1:0]     hslot_reg, hrank_reg, lslot_reg;
    logic [CODE_W-1:0] lcode_reg;

    // decision
    logic [SW-1:0]     tgt_reg, slot_reg;
    logic [CW-1:0]     p_reg;
    logic              twr_reg, ev_reg, new_reg;
    logic [CODE_W-1:0] evc_reg;
    logic [SW-1:0]     dec_tgt, dec_slot;
    logic [CW-1:0]     dec_p;
    logic              dec_twr, dec_ev, dec_new;
    logic [PW-1:0]     prod;
    logic [CW-1:0]     cnt;

    // output register
    out_item_t         out_reg;
    logic              ov_reg;
    logic              can_load;

    // ram and divider ports
    logic              ram_we;
    logic [SW-1:0]     ram_waddr, ram_raddr;
    logic [EW-1:0]     ram_wdata, ram_rdata;
    logic [CODE_W-1:0] rd_code;
    logic [SW-1:0]     rd_rank;
    logic              div_start, div_done;
    logic [DW-1:0]     div_a, div_b, div_q, div_r;
    logic [MW-1:0]     left_full, top_full;
    logic              cfg_wr;

    gal_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gal_div #(
        .W (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // configuration port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CELL_HEIGHT) ? {21'd0, ch_reg} : {21'd0, cw_reg};

    // clamp sizes into the usable range
    assign cwc = (cw_reg < SIZE_MIN) ? SIZE_MIN : ((cw_reg > SIZE_MAX) ? SIZE_MAX : cw_reg);
    assign chc = (ch_reg < SIZE_MIN) ? SIZE_MIN : ((ch_reg > SIZE_MAX) ? SIZE_MAX : ch_reg);

    assign in_stall = (state_reg != S_IDLE);
    assign rd_code  = ram_rdata[EW-1:SW];
    assign rd_rank  = ram_rdata[SW-1:0];
    assign walk_end = (iss_reg == n_reg) && !pv_reg;
    assign can_load = !ov_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_DCOLS;
            S_DCOLS:  if (div_done) state_next = S_DROWS;
            S_DROWS:  if (div_done) state_next = S_SCAN;
            S_SCAN:   if (walk_end) state_next = S_DECIDE;
            S_DECIDE: state_next = S_UPD;
            S_UPD:    if (walk_end) state_next = S_DCELL;
            S_DCELL:  if (div_done) state_next = S_DONE;
            S_DONE:   if (can_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // decision on hit, fresh placement or eviction
    assign prod = PW'(cols_reg) * PW'(rows_reg);
    assign cnt  = (prod > PW'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(prod);

    always_comb
    begin
        dec_tgt  = hslot_reg;
        dec_slot = hslot_reg;
        dec_p    = '0;
        dec_twr  = 1'b0;
        dec_ev   = 1'b0;
        dec_new  = 1'b0;
        priority if (hit_reg)
        begin
            dec_p   = peek_reg ? '0 : CW'(hrank_reg);
            dec_twr = !peek_reg;
        end
        else if (n_reg < cnt)
        begin
            dec_new  = 1'b1;
            dec_slot = n_reg[SW-1:0];
            dec_tgt  = n_reg[SW-1:0];
            dec_p    = n_reg;
        end
        else
        begin
            dec_ev   = 1'b1;
            dec_slot = lslot_reg;
            dec_tgt  = lslot_reg;
            dec_p    = n_reg - 1'b1;
            dec_twr  = 1'b1;
        end
    end

    // outputs of the sequencer: divider and ram ports
    always_comb
    begin
        div_start = 1'b0;
        div_a     = DW'(ATLAS_WIDTH);
        div_b     = DW'(cwc);
        ram_we    = 1'b0;
        ram_waddr = ps_reg;
        ram_wdata = {code_reg, SW'(0)};
        ram_raddr = iss_reg[SW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                div_start = in_valid;
            end
            S_DCOLS:
            begin
                div_start = div_done;
                div_a     = DW'(ATLAS_HEIGHT);
                div_b     = DW'(chc);
            end
            S_DECIDE:
            begin
                // fresh entry written ahead of the renumbering pass
                ram_we    = dec_new;
                ram_waddr = n_reg[SW-1:0];
            end
            S_UPD:
            begin
                if (pv_reg)
                begin
                    if (twr_reg && (ps_reg == tgt_reg))
                    begin
                        ram_we = 1'b1;
                    end
                    else if (CW'(rd_rank) < p_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_code, rd_rank + 1'b1};
                    end
                end
                div_start = walk_end;
                div_a     = DW'(slot_reg);
                div_b     = cols_reg;
            end
            S_DROWS, S_SCAN, S_DCELL, S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cw_reg    <= SIZE_RESET;
            ch_reg    <= SIZE_RESET;
            n_reg     <= '0;
            iss_reg   <= '0;
            pv_reg    <= 1'b0;
            hit_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && (paddr[2] == REG_CELL_WIDTH))
            begin
                cw_reg <= pwdata[SIZE_W-1:0];
            end
            if (cfg_wr && (paddr[2] == REG_CELL_HEIGHT))
            begin
                ch_reg <= pwdata[SIZE_W-1:0];
            end

            if ((state_reg == S_SCAN) || (state_reg == S_UPD))
            begin
                if (iss_reg < n_reg)
                begin
                    iss_reg <= iss_reg + 1'b1;
                    pv_reg  <= 1'b1;
                end
                else
                begin
                    pv_reg <= 1'b0;
                end
            end
            else
            begin
                iss_reg <= '0;
                pv_reg  <= 1'b0;
            end

            if (state_reg == S_DROWS)
            begin
                hit_reg <= 1'b0;
            end
            else if ((state_reg == S_SCAN) && pv_reg && (rd_code == code_reg))
            begin
                hit_reg <= 1'b1;
            end

            if ((state_reg == S_UPD) && walk_end && new_reg)
            begin
                n_reg <= n_reg + 1'b1;
            end

            if ((state_reg == S_DONE) && can_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload registers
    assign left_full = MW'(div_r) * MW'(cwc);
    assign top_full  = MW'(div_q) * MW'(chc);

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            code_reg <= in_data.glyph_code;
            peek_reg <= in_data.mode;
        end
        if ((state_reg == S_DCOLS) && div_done)
        begin
            cols_reg <= (div_q == '0) ? DW'(1) : div_q;
        end
        if ((state_reg == S_DROWS) && div_done)
        begin
            rows_reg <= (div_q == '0) ? DW'(1) : div_q;
        end
        if (((state_reg == S_SCAN) || (state_reg == S_UPD)) && (iss_reg < n_reg))
        begin
            ps_reg <= iss_reg[SW-1:0];
        end
        if ((state_reg == S_SCAN) && pv_reg)
        begin
            if (rd_code == code_reg)
            begin
                hslot_reg <= ps_reg;
                hrank_reg <= rd_rank;
            end
            if (CW'(rd_rank) == (n_reg - 1'b1))
            begin
                lslot_reg <= ps_reg;
                lcode_reg <= rd_code;
            end
        end
        if (state_reg == S_DECIDE)
        begin
            tgt_reg  <= dec_tgt;
            slot_reg <= dec_slot;
            p_reg    <= dec_p;
            twr_reg  <= dec_twr;
            ev_reg   <= dec_ev;
            new_reg  <= dec_new;
            evc_reg  <= dec_ev ? lcode_reg : '0;
        end
        if ((state_reg == S_DONE) && can_load)
        begin
            out_reg.was_resident <= hit_reg;
            out_reg.cell_left    <= (left_full > MW'(POS_MAX)) ? POS_MAX : left_full[POS_W-1:0];
            out_reg.cell_top     <= (top_full > MW'(POS_MAX)) ? POS_MAX : top_full[POS_W-1:0];
            out_reg.evicted      <= ev_reg;
            out_reg.evicted_code <= evc_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(MAX_CELLS))
        else $error("cells in use beyond capacity");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_reg.evicted) |-> !out_reg.was_resident)
        else $error("eviction reported on a resident glyph");

    a_rmw_addr: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UPD) && ram_we && (iss_reg < n_reg)) |-> (ram_waddr != ram_raddr))
        else $error("renumbering pass reads the entry it writes");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/gal_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module gal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// File: hw/rtl/gal_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module gal_div #(
    parameter int W = 11
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic      [W-1:0] quotient,
    output logic      [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     q_reg;
    logic [W-1:0]     r_reg;
    logic [W-1:0]     d_reg;
    logic [W:0]       shifted;
    logic [W:0]       diff;

    assign shifted = {r_reg, q_reg[W-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (!diff[W])
            begin
                r_reg <= diff[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
        else if (start)
        begin
            r_reg <= '0;
            q_reg <= dividend;
            d_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule
`default_nettype wire

// File: tb/tb_glyph_atlas_lru_slot_cache_top.sv
// self-checking testbench for the glyph atlas lru slot cache
`timescale 1ns / 1ps
`default_nettype none
module tb_glyph_atlas_lru_slot_cache_top;
    import gal_pkg::*;

    localparam int AW = 1024;
    localparam int AH = 1024;
    localparam int NCELLS = 256;
    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam int CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    glyph_atlas_lru_slot_cache_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state: a copy of the cache
    logic [10:0]       mdl_width;
    logic [10:0]       mdl_height;
    logic [CODE_W-1:0] mdl_code [NCELLS];
    logic [7:0]        mdl_cell [NCELLS];
    int                mdl_rank [NCELLS];   // recency list, index 0 most recent
    int                mdl_used;

    in_item_t  access_queue [$];   // items waiting to be offered
    out_item_t lookup_queue [$];   // predicted lookups not yet seen
    int        mismatches;
    int        accepted_items;
    int        cycle_count;

    function automatic int clamp_size(logic [10:0] v);
        if (v < 8) return 8;
        if (v > 1024) return 1024;
        return int'(v);
    endfunction

    function automatic int grid_cols();
        int c;
        c = AW / clamp_size(mdl_width);
        return (c == 0) ? 1 : c;
    endfunction

    function automatic int cell_total();
        int n;
        n = grid_cols() * ((AH / clamp_size(mdl_height) == 0) ? 1 : AH / clamp_size(mdl_height));
        return (n > NCELLS) ? NCELLS : n;
    endfunction

    // move the recency entry at position p to the front
    function automatic void promote(int p, int slot);
        for (int i = p; i > 0; i--) mdl_rank[i] = mdl_rank[i-1];
        mdl_rank[0] = slot;
    endfunction

    // look one access up in the predicted cache and return the result item
    function automatic out_item_t lookup_glyph(in_item_t it);
        out_item_t r;
        int  p;
        int  slot;
        int  cols;
        int  lx;
        int  ly;
        logic hit;
        hit = 1'b0;
        slot = 0;
        r = '0;
        for (p = 0; p < mdl_used; p++)
        begin
            if (mdl_code[mdl_rank[p]] == it.glyph_code)
            begin
                hit = 1'b1;
                slot = mdl_rank[p];
                break;
            end
        end
        if (hit)
        begin
            if (!it.mode) promote(p, slot);
        end
        else if (mdl_used < cell_total())
        begin
            slot = mdl_used;
            mdl_code[slot] = it.glyph_code;
            mdl_cell[slot] = 8'(mdl_used);
            promote(mdl_used, slot);
            mdl_used++;
        end
        else
        begin
            slot = mdl_rank[mdl_used-1];
            r.evicted = 1'b1;
            r.evicted_code = mdl_code[slot];
            mdl_code[slot] = it.glyph_code;
            promote(mdl_used-1, slot);
        end
        cols = grid_cols();
        lx = (mdl_cell[slot] % cols) * clamp_size(mdl_width);
        ly = (mdl_cell[slot] / cols) * clamp_size(mdl_height);
        r.was_resident = hit;
        r.cell_left = (lx > 1023) ? POS_MAX : 10'(lx);
        r.cell_top  = (ly > 1023) ? POS_MAX : 10'(ly);
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle counter and overall timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[glyph_atlas_lru_slot_cache_top] ERROR");
            $finish;
        end
    end

    // sender idling: calm stretch between 300 and 500 accepted items
    logic send_idle;
    always @(negedge clk)
        send_idle <= (accepted_items > 300 && accepted_items < 500) ? 1'b0
                     : ($urandom_range(99) < 18);

    // acceptance of an input item and its prediction
    logic took_item;
    always @(posedge clk)
    begin
        took_item <= in_valid && !in_stall && rst_n;
        if (in_valid && !in_stall && rst_n)
        begin
            lookup_queue.push_back(lookup_glyph(in_data));
            accepted_items <= accepted_items + 1;
        end
    end

    // driver: offer the head of the access queue, advance on acceptance
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (took_item)
                void'(access_queue.pop_front());
            // a stalled item stays as it is
            if (!in_valid || took_item)
            begin
                if ((access_queue.size() > 0) && !send_idle)
                begin
                    in_data  <= access_queue[0];
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    int hold_left;
    logic hold_done;
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_items == 600)
        begin
            hold_done <= 1'b1;
            hold_left <= 2000;
            out_stall <= 1'b1;
        end
        else if (accepted_items > 300 && accepted_items < 500)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 18);
    end

    // monitor: compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (lookup_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item %h", out_data);
            end
            else
            begin
                want = lookup_queue.pop_front();
                if (want !== out_data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want res=%0d l=%0d t=%0d ev=%0d evc=%h,",
                                  " got res=%0d l=%0d t=%0d ev=%0d evc=%h"},
                            want.was_resident, want.cell_left, want.cell_top,
                            want.evicted, want.evicted_code,
                            out_data.was_resident, out_data.cell_left,
                            out_data.cell_top, out_data.evicted, out_data.evicted_code);
                end
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [10:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
        pwdata <= {21'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_WIDTH) mdl_width = value;
        else mdl_height = value;
    endtask

    // wait until the queues drain, then a settle gap before a register write
    task automatic drain();
        while (access_queue.size() > 0 || in_valid || lookup_queue.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic in_item_t make_item(logic [CODE_W-1:0] c, logic m);
        in_item_t it;
        it.glyph_code = c;
        it.mode = m;
        return it;
    endfunction

    // random batch drawn from a small pool so hits, peeks and evictions mix
    task automatic random_batch(int count, int pool);
        logic [CODE_W-1:0] c;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                c = CODE_W'($urandom);
            else
                c = CODE_W'($urandom_range(pool)) ^ 21'h15A5A0;
            access_queue.push_back(make_item(c, $urandom_range(3) == 0));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; accepted_items = 0; cycle_count = 0;
        hold_left = 0; hold_done = 1'b0; send_idle = 1'b0; took_item = 1'b0;
        mdl_width = SIZE_RESET; mdl_height = SIZE_RESET; mdl_used = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tiny grid: 2 cells with 512 texel cells, shows eviction at once
        reg_write(ADDR_WIDTH, 11'd512);
        reg_write(ADDR_HEIGHT, 11'd1024);
        access_queue.push_back(make_item(21'h000000, 1'b0));
        access_queue.push_back(make_item(21'h1FFFFF, 1'b0));
        access_queue.push_back(make_item(21'h000000, 1'b1));   // resident peek
        access_queue.push_back(make_item(21'h10FFFF, 1'b1));   // peek of a missing glyph
        access_queue.push_back(make_item(21'h1FFFFF, 1'b0));
        access_queue.push_back(make_item(21'h000041, 1'b0));
        drain();
        // out of range sizes: below 8 and above 1024, 128 cells for 256 entries
        reg_write(ADDR_WIDTH, 11'd0);
        reg_write(ADDR_HEIGHT, 11'h7FF);
        access_queue.push_back(make_item(21'h0AAAAA, 1'b0));
        access_queue.push_back(make_item(21'h155555, 1'b1));
        drain();
        // odd sizes after a size change, with a single column of cells
        reg_write(ADDR_WIDTH, 11'd1000);
        reg_write(ADDR_HEIGHT, 11'd8);
        access_queue.push_back(make_item(21'h000041, 1'b0));
        access_queue.push_back(make_item(21'h0AAAAA, 1'b0));
        drain();
        reg_write(ADDR_WIDTH, 11'd7);
        reg_write(ADDR_HEIGHT, 11'd7);
        random_batch(60, 300);
        drain();
        reg_write(ADDR_WIDTH, 11'd1024);
        reg_write(ADDR_HEIGHT, 11'd1024);
        random_batch(40, 4);
        drain();
        reg_write(ADDR_WIDTH, 11'd200);
        reg_write(ADDR_HEIGHT, 11'd96);
        random_batch(300, 40);
        drain();
        reg_write(ADDR_WIDTH, SIZE_RESET);
        reg_write(ADDR_HEIGHT, 11'd33);
        random_batch(540, 400);
        drain();

        if (mismatches == 0)
            $display("[glyph_atlas_lru_slot_cache_top] OK");
        else
            $display("[glyph_atlas_lru_slot_cache_top] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hw/rtl/gal_pkg.sv
hw/rtl/gal_ram.sv
hw/rtl/gal_div.sv
hw/rtl/glyph_atlas_lru_slot_cache_top.sv
tb/tb_glyph_atlas_lru_slot_cache_top.sv
